### sv/skac_pkg.sv
// Shared types, constants and constant tables for the soft-knee compressor.
`default_nettype none
package skac_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int GAIN_TABLE_DEPTH = 1024;
    localparam int GAIN_IDX_BITS    = $clog2(GAIN_TABLE_DEPTH);

    localparam int P_W     = $clog2(SAMPLE_BITS);
    localparam int MAG_W   = P_W + 16;
    localparam int LPROD_W = MAG_W + 19;
    localparam int X_W     = 17;
    localparam int GR_W    = 14;
    localparam int K_W     = 12;
    localparam int MANT_W  = 31;
    localparam int MANT_FRAC = 30;

    localparam int SQ_STEPS  = 16;
    localparam int DIV_STEPS = K_W;
    localparam int CNT_W     = 4;
    localparam int MIDX_W    = $clog2(GAIN_IDX_BITS);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [18:0]                DB_PER_LOG2_Q16 = 19'd394566;
    localparam logic [21:0]                LOG2_PER_DB_Q24 = 22'd2786635;
    localparam logic signed [X_W-1:0]      SILENCE_DB      = -17'sd25600;
    localparam logic [GR_W-1:0]            GR_MAX          = 14'd16383;
    localparam logic [15:0]                DIV10_RECIP     = 16'd52429;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_KNEE      = 3'd1,
        REG_SLOPE     = 3'd2,
        REG_ATTACK    = 3'd3,
        REG_RELEASE   = 3'd4,
        REG_MAKEUP    = 3'd5,
        REG_USE_KEY   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [14:0] threshold_db;
        logic [11:0]        knee_width_db;
        logic [15:0]        comp_slope;
        logic [23:0]        attack_coeff;
        logic [23:0]        release_coeff;
        logic [12:0]        makeup_db;
        logic               use_key;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ENV_MUL,
        OP_ENV_UPD,
        OP_NORM,
        OP_SQ,
        OP_LVL_MUL,
        OP_LVL,
        OP_GR_PREP,
        OP_GR_MUL,
        OP_DIV_INIT,
        OP_DIV,
        OP_GR_SEL,
        OP_GAIN_MUL,
        OP_GAIN_E,
        OP_MANT,
        OP_MUL_L,
        OP_SAT_L,
        OP_MUL_R,
        OP_SAT_R,
        OP_METER,
        OP_METER_DIV,
        OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_NORM,
        ST_SQ,
        ST_LVL_MUL,
        ST_LVL,
        ST_GR_PREP,
        ST_GR_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_GR_SEL,
        ST_GAIN_MUL,
        ST_GAIN_E,
        ST_MANT,
        ST_MUL_L,
        ST_SAT_L,
        ST_MUL_R,
        ST_SAT_R,
        ST_METER,
        ST_METER_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic div;
    } t_stat;

    typedef logic [GAIN_IDX_BITS-1:0][MANT_W-1:0] t_roots;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        x = v;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q1.30 for k = 1.., each the integer root of the previous
    function automatic t_roots calc_roots();
        t_roots      t;
        logic [63:0] r;
        r = 64'd2 << MANT_FRAC;
        for (int k = 0; k < GAIN_IDX_BITS; k++) begin
            r    = isqrt(r << MANT_FRAC);
            t[k] = r[MANT_W-1:0];
        end
        return t;
    endfunction

    localparam t_roots ROOTS = calc_roots();

endpackage
`default_nettype wire

### sv/skac_ifs.sv
// Item channel interfaces for frames in and gained frames out.
`default_nettype none
interface skac_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [skac_pkg::SAMPLE_BITS-1:0]    audio_left;
    logic signed [skac_pkg::SAMPLE_BITS-1:0]    audio_right;
    logic signed [skac_pkg::SAMPLE_BITS-1:0]    key_left;
    logic signed [skac_pkg::SAMPLE_BITS-1:0]    key_right;
    logic                                       block_last;

    modport source(output valid, audio_left, audio_right, key_left, key_right, block_last,
                   input ready);
    modport sink(input valid, audio_left, audio_right, key_left, key_right, block_last,
                 output ready);
endinterface

interface skac_out_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [skac_pkg::SAMPLE_BITS-1:0]    out_left;
    logic signed [skac_pkg::SAMPLE_BITS-1:0]    out_right;
    logic [skac_pkg::GR_W-1:0]                  reduction_db;
    logic [skac_pkg::GR_W-1:0]                  meter_db;

    modport source(output valid, out_left, out_right, reduction_db, meter_db, input ready);
    modport sink(input valid, out_left, out_right, reduction_db, meter_db, output ready);
endinterface
`default_nettype wire

### sv/soft_knee_audio_compressor.sv
// Soft-knee stereo compressor top level: one frame item in, one gained frame item out.
// The sequencer accepts a new item only in idle, once the previous result is in the output
// register; per item it runs 16 log squarings, 10 mantissa steps and, in the knee, a 12-step
// divide. The output register lets the next item be taken while a result waits. Reset
// (synchronous, active low) clears the envelope, block peak and meter, and loads the default
// register values.
`default_nettype none
module soft_knee_audio_compressor (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    skac_in_if.sink                            i_in,
    skac_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [skac_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [skac_pkg::DATA_W-1:0]   pwdata,
    output logic      [skac_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    skac_pkg::t_cfg  w_cfg;
    skac_pkg::t_cmd  w_cmd;
    skac_pkg::t_stat w_stat;

    skac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    skac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    skac_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg          (w_cfg),
        .i_audio_left   (i_in.audio_left),
        .i_audio_right  (i_in.audio_right),
        .i_key_left     (i_in.key_left),
        .i_key_right    (i_in.key_right),
        .i_block_last   (i_in.block_last),
        .o_stat         (w_stat),
        .o_out_left     (o_out.out_left),
        .o_out_right    (o_out.out_right),
        .o_reduction_db (o_out.reduction_db),
        .o_meter_db     (o_out.meter_db)
    );

endmodule
`default_nettype wire

### sv/skac_regs.sv
// APB configuration register bank.
`default_nettype none
module skac_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [skac_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [skac_pkg::DATA_W-1:0]   pwdata,
    output logic      [skac_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output skac_pkg::t_cfg                     o_cfg
);

    skac_pkg::t_cfg     r_cfg;
    skac_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx  = skac_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_db  <= -15'sd5120;
            r_cfg.knee_width_db <= 12'd768;
            r_cfg.comp_slope    <= 16'd49152;
            r_cfg.attack_coeff  <= 24'd34917;
            r_cfg.release_coeff <= 24'd3495;
            r_cfg.makeup_db     <= 13'd0;
            r_cfg.use_key       <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                skac_pkg::REG_THRESHOLD: r_cfg.threshold_db  <= signed'(pwdata[14:0]);
                skac_pkg::REG_KNEE:      r_cfg.knee_width_db <= pwdata[11:0];
                skac_pkg::REG_SLOPE:     r_cfg.comp_slope    <= pwdata[15:0];
                skac_pkg::REG_ATTACK:    r_cfg.attack_coeff  <= pwdata[23:0];
                skac_pkg::REG_RELEASE:   r_cfg.release_coeff <= pwdata[23:0];
                skac_pkg::REG_MAKEUP:    r_cfg.makeup_db     <= pwdata[12:0];
                skac_pkg::REG_USE_KEY:   r_cfg.use_key       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            skac_pkg::REG_THRESHOLD: prdata = {17'b0, r_cfg.threshold_db};
            skac_pkg::REG_KNEE:      prdata = {20'b0, r_cfg.knee_width_db};
            skac_pkg::REG_SLOPE:     prdata = {16'b0, r_cfg.comp_slope};
            skac_pkg::REG_ATTACK:    prdata = {8'b0, r_cfg.attack_coeff};
            skac_pkg::REG_RELEASE:   prdata = {8'b0, r_cfg.release_coeff};
            skac_pkg::REG_MAKEUP:    prdata = {19'b0, r_cfg.makeup_db};
            skac_pkg::REG_USE_KEY:   prdata = {31'b0, r_cfg.use_key};
            default:                 prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### sv/skac_ctrl.sv
// Sequencer that steps the datapath through one item and owns the handshakes.
`default_nettype none
module skac_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  skac_pkg::t_stat    i_stat,
    output skac_pkg::t_cmd     o_cmd
);

    skac_pkg::t_state           r_state, n_state;
    logic [skac_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skac_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd.op    = skac_pkg::OP_NONE;
        o_cmd.cnt   = r_cnt;
        unique case (r_state)
            skac_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = skac_pkg::OP_LOAD;
                    n_state  = skac_pkg::ST_ENV_MUL;
                end
            end
            skac_pkg::ST_ENV_MUL: begin
                o_cmd.op = skac_pkg::OP_ENV_MUL;
                n_state  = skac_pkg::ST_ENV_UPD;
            end
            skac_pkg::ST_ENV_UPD: begin
                o_cmd.op = skac_pkg::OP_ENV_UPD;
                n_state  = skac_pkg::ST_NORM;
            end
            skac_pkg::ST_NORM: begin
                o_cmd.op = skac_pkg::OP_NORM;
                n_cnt    = '0;
                n_state  = skac_pkg::ST_SQ;
            end
            skac_pkg::ST_SQ: begin
                o_cmd.op = skac_pkg::OP_SQ;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == skac_pkg::CNT_W'(skac_pkg::SQ_STEPS - 1)) begin
                    n_state = skac_pkg::ST_LVL_MUL;
                end
            end
            skac_pkg::ST_LVL_MUL: begin
                o_cmd.op = skac_pkg::OP_LVL_MUL;
                n_state  = skac_pkg::ST_LVL;
            end
            skac_pkg::ST_LVL: begin
                o_cmd.op = skac_pkg::OP_LVL;
                n_state  = skac_pkg::ST_GR_PREP;
            end
            skac_pkg::ST_GR_PREP: begin
                o_cmd.op = skac_pkg::OP_GR_PREP;
                n_state  = skac_pkg::ST_GR_MUL;
            end
            skac_pkg::ST_GR_MUL: begin
                o_cmd.op = skac_pkg::OP_GR_MUL;
                // knee region needs the divide by the knee width
                n_state  = i_stat.div ? skac_pkg::ST_DIV_INIT : skac_pkg::ST_GR_SEL;
            end
            skac_pkg::ST_DIV_INIT: begin
                o_cmd.op = skac_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = skac_pkg::ST_DIV;
            end
            skac_pkg::ST_DIV: begin
                o_cmd.op = skac_pkg::OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == skac_pkg::CNT_W'(skac_pkg::DIV_STEPS - 1)) begin
                    n_state = skac_pkg::ST_GR_SEL;
                end
            end
            skac_pkg::ST_GR_SEL: begin
                o_cmd.op = skac_pkg::OP_GR_SEL;
                n_state  = skac_pkg::ST_GAIN_MUL;
            end
            skac_pkg::ST_GAIN_MUL: begin
                o_cmd.op = skac_pkg::OP_GAIN_MUL;
                n_state  = skac_pkg::ST_GAIN_E;
            end
            skac_pkg::ST_GAIN_E: begin
                o_cmd.op = skac_pkg::OP_GAIN_E;
                n_cnt    = '0;
                n_state  = skac_pkg::ST_MANT;
            end
            skac_pkg::ST_MANT: begin
                o_cmd.op = skac_pkg::OP_MANT;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == skac_pkg::CNT_W'(skac_pkg::GAIN_IDX_BITS - 1)) begin
                    n_state = skac_pkg::ST_MUL_L;
                end
            end
            skac_pkg::ST_MUL_L: begin
                o_cmd.op = skac_pkg::OP_MUL_L;
                n_state  = skac_pkg::ST_SAT_L;
            end
            skac_pkg::ST_SAT_L: begin
                o_cmd.op = skac_pkg::OP_SAT_L;
                n_state  = skac_pkg::ST_MUL_R;
            end
            skac_pkg::ST_MUL_R: begin
                o_cmd.op = skac_pkg::OP_MUL_R;
                n_state  = skac_pkg::ST_SAT_R;
            end
            skac_pkg::ST_SAT_R: begin
                o_cmd.op = skac_pkg::OP_SAT_R;
                n_state  = skac_pkg::ST_METER;
            end
            skac_pkg::ST_METER: begin
                o_cmd.op = skac_pkg::OP_METER;
                n_state  = skac_pkg::ST_METER_DIV;
            end
            skac_pkg::ST_METER_DIV: begin
                o_cmd.op = skac_pkg::OP_METER_DIV;
                n_state  = skac_pkg::ST_OUT;
            end
            skac_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = skac_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = skac_pkg::ST_IDLE;
                end
            end
            default: n_state = skac_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### sv/skac_dp.sv
// Datapath: detector, envelope, log level, knee, gain exponent, output scaling and block meter.
`default_nettype none
module skac_dp (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  skac_pkg::t_cmd                                 i_cmd,
    input  skac_pkg::t_cfg                                 i_cfg,
    input  wire logic signed [skac_pkg::SAMPLE_BITS-1:0]   i_audio_left,
    input  wire logic signed [skac_pkg::SAMPLE_BITS-1:0]   i_audio_right,
    input  wire logic signed [skac_pkg::SAMPLE_BITS-1:0]   i_key_left,
    input  wire logic signed [skac_pkg::SAMPLE_BITS-1:0]   i_key_right,
    input  wire logic                                      i_block_last,
    output skac_pkg::t_stat                                o_stat,
    output logic signed [skac_pkg::SAMPLE_BITS-1:0]        o_out_left,
    output logic signed [skac_pkg::SAMPLE_BITS-1:0]        o_out_right,
    output logic [skac_pkg::GR_W-1:0]                      o_reduction_db,
    output logic [skac_pkg::GR_W-1:0]                      o_meter_db
);

    localparam int SB  = skac_pkg::SAMPLE_BITS;
    localparam int EPW = SB + 24;
    localparam int APW = SB + skac_pkg::MANT_W;
    localparam int LW  = skac_pkg::LPROD_W;
    localparam int MW  = skac_pkg::MAG_W;
    localparam int XW  = skac_pkg::X_W;
    localparam int GW  = skac_pkg::GR_W;
    localparam int KW  = skac_pkg::K_W;
    localparam int IW  = skac_pkg::GAIN_IDX_BITS;
    localparam int MT  = skac_pkg::MANT_W;

    function automatic logic [SB-1:0] abs_s(input logic signed [SB-1:0] v);
        logic [SB-1:0] u;
        u = v;
        return v[SB-1] ? (~u + 1'b1) : u;
    endfunction

    // item and state registers
    logic signed [SB-1:0]        r_al, r_ar;
    logic                        r_last;
    logic [SB-1:0]               r_d;
    logic [SB-1:0]               r_env;
    logic                        r_up;
    logic [EPW-1:0]              r_eprod;
    logic [23:0]                 r_m;
    logic [skac_pkg::P_W-1:0]    r_p;
    logic [15:0]                 r_frac;
    logic                        r_silent;
    logic [LW-1:0]               r_lprod;
    logic signed [XW-1:0]        r_x;
    logic                        r_zero, r_knee;
    logic [12:0]                 r_u;
    logic [14:0]                 r_xt;
    logic [25:0]                 r_uu;
    logic [30:0]                 r_lin;
    logic [KW-1:0]               r_rem, r_nsh, r_q;
    logic [GW-1:0]               r_gr;
    logic                        r_gneg;
    logic [35:0]                 r_gprod;
    logic signed [5:0]           r_n;
    logic [IW-1:0]               r_idx;
    logic [MT-1:0]               r_mant;
    logic [APW-1:0]              r_aprod;
    logic signed [SB-1:0]        r_ol, r_or;
    logic [GW-1:0]               r_peak, r_meter;
    logic [17:0]                 r_msum;
    logic signed [SB-1:0]        r_out_l, r_out_r;
    logic [GW-1:0]               r_out_gr, r_out_meter;

    // combinational next values
    logic signed [SB-1:0]        n_da, n_db;
    logic [SB:0]                 n_sum;
    logic                        n_up;
    logic [SB-1:0]               n_diff;
    logic [23:0]                 n_coef;
    logic [EPW-1:0]              n_eprod;
    logic [SB-1:0]               n_inc;
    logic [skac_pkg::P_W-1:0]    n_p;
    logic [SB+22:0]              n_norm;
    logic [47:0]                 n_sq;
    logic [24:0]                 n_sqs;
    logic [MW-1:0]               n_base, n_mag;
    logic [LW-1:0]               n_lprod;
    logic signed [XW-1:0]        n_x;
    logic signed [18:0]          n_xs, n_ts, n_ks, n_u, n_xt;
    logic [25:0]                 n_uu;
    logic [30:0]                 n_lin;
    logic [41:0]                 n_num;
    logic [KW:0]                 n_t13, n_rsub;
    logic                        n_ge;
    logic [GW-1:0]               n_gr;
    logic signed [15:0]          n_g;
    logic [15:0]                 n_absg;
    logic [35:0]                 n_gprod;
    logic [36:0]                 n_enum;
    logic signed [21:0]          n_e;
    logic [61:0]                 n_mprod;
    logic signed [SB-1:0]        n_ssel;
    logic [APW-1:0]              n_aprod;
    logic [6:0]                  n_sh;
    logic [APW-1:0]              n_shifted, n_lim, n_mg;
    logic                        n_neg;
    logic signed [SB-1:0]        n_sat;
    logic [GW-1:0]               n_pk;
    logic [17:0]                 n_msum;
    logic [33:0]                 n_mdiv;

    always_comb begin
        n_da  = i_cfg.use_key ? i_key_left  : i_audio_left;
        n_db  = i_cfg.use_key ? i_key_right : i_audio_right;
        n_sum = {1'b0, abs_s(n_da)} + {1'b0, abs_s(n_db)};

        n_up    = r_d > r_env;
        n_diff  = n_up ? (r_d - r_env) : (r_env - r_d);
        n_coef  = n_up ? i_cfg.attack_coeff : i_cfg.release_coeff;
        n_eprod = EPW'(n_coef) * EPW'(n_diff);
        n_inc   = r_eprod[EPW-1:24];

        // leading one of the envelope
        n_p = '0;
        for (int i = 0; i < SB; i++) begin
            if (r_env[i]) n_p = skac_pkg::P_W'(i);
        end
        n_norm = {r_env, 23'b0} >> n_p;

        n_sq  = 48'(r_m) * 48'(r_m);
        n_sqs = n_sq[47:23];

        n_base  = {skac_pkg::P_W'(SB - 1) - r_p, 16'h0};
        n_mag   = (n_base >= MW'(r_frac)) ? (n_base - MW'(r_frac)) : '0;
        n_lprod = LW'(n_mag) * LW'(skac_pkg::DB_PER_LOG2_Q16);
        n_x     = XW'(0) - signed'(XW'(r_lprod[LW-1:24]));

        n_xs = 19'(r_x);
        n_ts = 19'(i_cfg.threshold_db);
        n_ks = signed'({7'b0, i_cfg.knee_width_db});
        n_u  = n_xs - n_ts + n_ks;
        n_xt = n_xs - n_ts;

        n_uu  = 26'(r_u) * 26'(r_u);
        n_lin = 31'(r_xt) * 31'(i_cfg.comp_slope);
        n_num = 42'(r_uu) * 42'(i_cfg.comp_slope);

        // restoring divide by the knee width, one quotient bit per step
        n_t13  = {r_rem, r_nsh[KW-1]};
        n_ge   = n_t13 >= {1'b0, i_cfg.knee_width_db};
        n_rsub = n_t13 - {1'b0, i_cfg.knee_width_db};

        if (r_zero) begin
            n_gr = '0;
        end else if (r_knee) begin
            n_gr = GW'(r_q);
        end else if (r_lin[30:16] > 15'(skac_pkg::GR_MAX)) begin
            n_gr = skac_pkg::GR_MAX;
        end else begin
            n_gr = r_lin[29:16];
        end

        n_g     = signed'({3'b0, i_cfg.makeup_db}) - signed'({2'b0, r_gr});
        n_absg  = n_g[15] ? 16'(-n_g) : 16'(n_g);
        n_gprod = 36'(n_absg[13:0]) * 36'(skac_pkg::LOG2_PER_DB_Q24);
        // negative exponents round toward minus infinity
        n_enum  = {1'b0, r_gprod} + (r_gneg ? 37'd65535 : 37'd0);
        n_e     = r_gneg ? (22'sd0 - signed'({1'b0, n_enum[36:16]}))
                         : signed'({1'b0, n_enum[36:16]});

        n_mprod = 62'(r_mant) * 62'(skac_pkg::ROOTS[i_cmd.cnt[skac_pkg::MIDX_W-1:0]]);

        n_ssel  = (i_cmd.op == skac_pkg::OP_MUL_R) ? r_ar : r_al;
        n_aprod = APW'(abs_s(n_ssel)) * APW'(r_mant);

        n_sh      = 7'd30 - 7'(r_n);
        n_shifted = r_aprod >> n_sh;
        n_lim     = APW'(1) << (SB - 1);
        n_mg      = (n_shifted > n_lim) ? n_lim : n_shifted;
        n_neg     = (i_cmd.op == skac_pkg::OP_SAT_R) ? r_ar[SB-1] : r_al[SB-1];
        if (n_neg) begin
            n_sat = signed'(~n_mg[SB-1:0] + 1'b1);
        end else if (n_mg >= n_lim) begin
            n_sat = signed'(SB'(n_lim - 1'b1));
        end else begin
            n_sat = signed'(n_mg[SB-1:0]);
        end

        n_pk   = (r_gr > r_peak) ? r_gr : r_peak;
        n_msum = 18'(r_meter) * 18'd9 + 18'(n_pk) + 18'd5;
        // divide by ten via reciprocal; exact for sums below 2^18
        n_mdiv = 34'(r_msum) * 34'(skac_pkg::DIV10_RECIP);
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env   <= '0;
            r_peak  <= '0;
            r_meter <= '0;
        end else begin
            unique case (i_cmd.op)
                skac_pkg::OP_ENV_UPD: r_env <= r_up ? (r_env + n_inc) : (r_env - n_inc);
                skac_pkg::OP_METER:   r_peak <= n_pk;
                skac_pkg::OP_METER_DIV: begin
                    if (r_last) begin
                        r_meter <= n_mdiv[32:19];
                        r_peak  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            skac_pkg::OP_LOAD: begin
                r_al   <= i_audio_left;
                r_ar   <= i_audio_right;
                r_last <= i_block_last;
                r_d    <= n_sum[SB:1];
            end
            skac_pkg::OP_ENV_MUL: begin
                r_up    <= n_up;
                r_eprod <= n_eprod;
            end
            skac_pkg::OP_NORM: begin
                r_p      <= n_p;
                r_m      <= n_norm[23:0];
                r_silent <= (r_env == '0);
                r_frac   <= '0;
            end
            skac_pkg::OP_SQ: begin
                r_frac <= {r_frac[14:0], n_sqs[24]};
                r_m    <= n_sqs[24] ? n_sqs[24:1] : n_sqs[23:0];
            end
            skac_pkg::OP_LVL_MUL: r_lprod <= n_lprod;
            skac_pkg::OP_LVL:     r_x <= r_silent ? skac_pkg::SILENCE_DB : n_x;
            skac_pkg::OP_GR_PREP: begin
                r_zero <= (n_xs <= n_ts - n_ks);
                r_knee <= (i_cfg.knee_width_db != '0) && (n_xs < n_ts + n_ks);
                r_u    <= n_u[12:0];
                r_xt   <= n_xt[14:0];
            end
            skac_pkg::OP_GR_MUL: begin
                r_uu  <= n_uu;
                r_lin <= n_lin;
            end
            skac_pkg::OP_DIV_INIT: begin
                // quotient stays below the knee width, so the top bits start the remainder
                r_rem <= n_num[41:30];
                r_nsh <= n_num[29:18];
            end
            skac_pkg::OP_DIV: begin
                r_rem <= n_ge ? n_rsub[KW-1:0] : n_t13[KW-1:0];
                r_nsh <= {r_nsh[KW-2:0], 1'b0};
                r_q   <= {r_q[KW-2:0], n_ge};
            end
            skac_pkg::OP_GR_SEL: r_gr <= n_gr;
            skac_pkg::OP_GAIN_MUL: begin
                r_gneg  <= n_g[15];
                r_gprod <= n_gprod;
            end
            skac_pkg::OP_GAIN_E: begin
                r_n    <= n_e[21:16];
                r_idx  <= n_e[15 -: IW];
                r_mant <= MT'(1) << skac_pkg::MANT_FRAC;
            end
            skac_pkg::OP_MANT: begin
                if (r_idx[IW-1]) r_mant <= n_mprod[60:30];
                r_idx <= {r_idx[IW-2:0], 1'b0};
            end
            skac_pkg::OP_MUL_L, skac_pkg::OP_MUL_R: r_aprod <= n_aprod;
            skac_pkg::OP_SAT_L:  r_ol <= n_sat;
            skac_pkg::OP_SAT_R:  r_or <= n_sat;
            skac_pkg::OP_METER:  r_msum <= n_msum;
            skac_pkg::OP_OUT: begin
                r_out_l     <= r_ol;
                r_out_r     <= r_or;
                r_out_gr    <= r_gr;
                r_out_meter <= r_meter;
            end
            default: ;
        endcase
    end

    assign o_stat.div     = r_knee & ~r_zero;
    assign o_out_left     = r_out_l;
    assign o_out_right    = r_out_r;
    assign o_reduction_db = r_out_gr;
    assign o_meter_db     = r_out_meter;

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the soft-knee stereo compressor: frames in, gained frames out.
`default_nettype none
module tb;

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
        logic [13:0] gr;
        logic [13:0] meter;
    } t_gained;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [skac_pkg::ADDR_W-1:0] paddr;
    logic [skac_pkg::DATA_W-1:0] pwdata, prdata;

    skac_in_if  in_if();
    skac_out_if out_if();

    soft_knee_audio_compressor DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if), .o_out(out_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    skac_pkg::t_cfg  cfg;
    longint unsigned env_lvl;
    int unsigned     peak_gr;
    int unsigned     meter_lvl;

    t_gained gained_q[$];
    int      errors;
    int      frames_sent;
    int      frames_checked;
    int      cfg_writes;
    longint  cycles;
    bit      calm;
    int      stall_left;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout at %0t", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (calm) begin
            out_if.ready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_if.ready = 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_gained want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (gained_q.size() == 0) begin
                errors++;
                $display("%0t unexpected item out: L=%h R=%h gr=%0d meter=%0d", $time,
                         out_if.out_left, out_if.out_right, out_if.reduction_db,
                         out_if.meter_db);
            end else begin
                want = gained_q.pop_front();
                frames_checked++;
                if (out_if.out_left !== want.left) begin
                    errors++;
                    $display("%0t out_left exp %h got %h", $time, want.left, out_if.out_left);
                end
                if (out_if.out_right !== want.right) begin
                    errors++;
                    $display("%0t out_right exp %h got %h", $time, want.right,
                             out_if.out_right);
                end
                if (out_if.reduction_db !== want.gr) begin
                    errors++;
                    $display("%0t reduction_db exp %0d got %0d", $time, want.gr,
                             out_if.reduction_db);
                end
                if (out_if.meter_db !== want.meter) begin
                    errors++;
                    $display("%0t meter_db exp %0d got %0d", $time, want.meter,
                             out_if.meter_db);
                end
            end
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, trial;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = res | (64'd1 << b);
            if (trial * trial <= v) res = trial;
        end
        return res;
    endfunction

    function automatic longint unsigned mag_of(longint s);
        return s < 0 ? longint'(-s) : longint'(s);
    endfunction

    // envelope to Q8.8 dB, -100 dB for silence
    function automatic longint env_to_db(longint unsigned e);
        int              p;
        longint unsigned m, mag, frac;
        if (e == 0) return -25600;
        p = 0;
        while (p < 63 && (e >> (p + 1)) != 0) p++;
        m = (p <= 23) ? (e << (23 - p)) : (e >> (p - 23));
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 23;
            frac = frac << 1;
            if (m >= (64'd1 << 24)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        if (p > 23) p = 23;
        mag = longint'(23 - p) * 65536;
        mag = (mag >= frac) ? mag - frac : 0;
        return -longint'((mag * 64'd394566) >> 24);
    endfunction

    function automatic int unsigned knee_curve(longint x);
        longint          t, k;
        longint unsigned u, gr;
        t = cfg.threshold_db;
        k = cfg.knee_width_db;
        if (x <= t - k) return 0;
        if (k > 0 && x < t + k) begin
            u = x - t + k;
            gr = (u * u * cfg.comp_slope) / (longint'(k) << 18);
        end else begin
            gr = (longint'(x - t) * cfg.comp_slope) >> 16;
        end
        return gr > 16383 ? 16383 : int'(gr);
    endfunction

    function automatic logic [23:0] scale_sample(longint s, longint n, longint unsigned m);
        longint          sh, v;
        longint unsigned mag;
        sh = 30 - n;
        if (sh < 0) sh = 0;
        if (sh > 63) sh = 63;
        mag = (mag_of(s) * m) >> sh;
        if (mag > 64'd8388608) mag = 64'd8388608;
        v = s < 0 ? -longint'(mag) : longint'(mag);
        if (v > 8388607) v = 8388607;
        return v[23:0];
    endfunction

    function automatic t_gained compress_frame(logic signed [23:0] al, logic signed [23:0] ar,
                                              logic signed [23:0] kl, logic signed [23:0] kr,
                                              logic last);
        t_gained         res;
        longint unsigned d, f, idx, fq, m, r;
        longint          g, e, eo, n;
        int unsigned     gr;
        if (cfg.use_key) d = (mag_of(kl) + mag_of(kr)) >> 1;
        else d = (mag_of(al) + mag_of(ar)) >> 1;
        if (d > env_lvl) env_lvl = env_lvl + ((cfg.attack_coeff * (d - env_lvl)) >> 24);
        else env_lvl = env_lvl - ((cfg.release_coeff * (env_lvl - d)) >> 24);
        gr = knee_curve(env_to_db(env_lvl));
        g = longint'(cfg.makeup_db) - longint'(gr);
        if (g >= 0) e = longint'((longint'(g) * 64'd2786635) >> 16);
        else e = -longint'((longint'(-g) * 64'd2786635 + 65535) >> 16);
        eo = e + (longint'(64) << 16);
        n = (eo >>> 16) - 64;
        f = eo & 64'hFFFF;
        idx = (f * skac_pkg::GAIN_TABLE_DEPTH) >> 16;
        fq = (idx << 16) / skac_pkg::GAIN_TABLE_DEPTH;
        m = 64'd1 << 30;
        r = 64'd2 << 30;
        for (int k = 1; k <= 16; k++) begin
            r = int_sqrt(r << 30);
            if ((fq >> (16 - k)) & 1) m = (m * r) >> 30;
        end
        if (gr > peak_gr) peak_gr = gr;
        if (last) begin
            meter_lvl = (9 * meter_lvl + peak_gr + 5) / 10;
            peak_gr = 0;
        end
        res.left = scale_sample(al, n, m);
        res.right = scale_sample(ar, n, m);
        res.gr = gr[13:0];
        res.meter = meter_lvl[13:0];
        return res;
    endfunction

    task automatic send_frame(logic [23:0] al, logic [23:0] ar, logic [23:0] kl,
                              logic [23:0] kr, logic last);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.audio_left = al;
        in_if.audio_right = ar;
        in_if.key_left = kl;
        in_if.key_right = kr;
        in_if.block_last = last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        gained_q.push_back(compress_frame(al, ar, kl, kr, last));
        frames_sent++;
        @(negedge i_clk);
        in_if.valid = 1'b0;
    endtask

    task automatic write_reg(skac_pkg::t_reg_idx idx, logic [31:0] value);
        // only while idle: drain and let the pipeline settle
        while (gained_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = skac_pkg::ADDR_W'(idx) << 2;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            skac_pkg::REG_THRESHOLD: cfg.threshold_db = value[14:0];
            skac_pkg::REG_KNEE:      cfg.knee_width_db = value[11:0];
            skac_pkg::REG_SLOPE:     cfg.comp_slope = value[15:0];
            skac_pkg::REG_ATTACK:    cfg.attack_coeff = value[23:0];
            skac_pkg::REG_RELEASE:   cfg.release_coeff = value[23:0];
            skac_pkg::REG_MAKEUP:    cfg.makeup_db = value[12:0];
            skac_pkg::REG_USE_KEY:   cfg.use_key = value[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_all(logic [14:0] thr, logic [11:0] knee, logic [15:0] slope,
                           logic [23:0] att, logic [23:0] rel, logic [12:0] mk, logic key);
        write_reg(skac_pkg::REG_THRESHOLD, {17'd0, thr});
        write_reg(skac_pkg::REG_KNEE, {20'd0, knee});
        write_reg(skac_pkg::REG_SLOPE, {16'd0, slope});
        write_reg(skac_pkg::REG_ATTACK, {8'd0, att});
        write_reg(skac_pkg::REG_RELEASE, {8'd0, rel});
        write_reg(skac_pkg::REG_MAKEUP, {19'd0, mk});
        write_reg(skac_pkg::REG_USE_KEY, {31'd0, key});
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(signed'($urandom_range(0, 2000)) - 1000);
            3: return 24'($urandom_range(0, 32'hFFFF)) << $urandom_range(0, 8);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                       $urandom_range(0, 7) == 0);
    endtask

    task automatic test_directed();
        send_frame(24'd0, 24'd0, 24'd0, 24'd0, 1'b0);                 // silence
        send_frame(24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'd0, 1'b0);
        send_frame(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b1);
        send_frame(24'h000001, 24'hFFFFFF, 24'd0, 24'd0, 1'b0);
        send_frame(24'h400000, 24'hC00000, 24'h123456, 24'hABCDEF, 1'b1);
        // fast attack drives deep into compression, then release back toward silence
        set_all(15'h7000, 12'd768, 16'd49152, 24'hFFFFFF, 24'h800000, 13'd0, 1'b0);
        for (int i = 0; i < 4; i++) send_frame(24'h7FFFFF, 24'h800000, 24'd0, 24'd0, i == 3);
        for (int i = 0; i < 4; i++) send_frame(24'd0, 24'd0, 24'h7FFFFF, 24'd0, i == 3);
        // hard knee, full makeup
        set_all(15'h6C00, 12'd0, 16'd62259, 24'hFFFFFF, 24'hFFFFFF, 13'd6144, 1'b0);
        send_frame(24'h7FFFFF, 24'h000100, 24'd0, 24'd0, 1'b1);
        send_frame(24'h001000, 24'hFFF000, 24'd0, 24'd0, 1'b1);
        send_frame(24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
    endtask

    task automatic test_default_random();
        set_all(15'h6C00, 12'd768, 16'd49152, 24'd34917, 24'd3495, 13'd0, 1'b0);
        send_random(60);
    endtask

    task automatic test_soft_knee();
        set_all(15'h7400, 12'd3072, 16'd62259, 24'h200000, 24'h080000, 13'd1024, 1'b0);
        send_random(90);
    endtask

    task automatic test_sidechain();
        set_all(15'h7B00, 12'd512, 16'd32768, 24'h400000, 24'h100000, 13'd3000, 1'b1);
        send_random(90);
    endtask

    task automatic test_extremes();
        set_all(15'h4400, 12'd3072, 16'd62259, 24'hFFFFFF, 24'hFFFFFF, 13'd6144, 1'b1);
        send_random(60);
        set_all(15'h0000, 12'd0, 16'd0, 24'd0, 24'd0, 13'd0, 1'b0);
        send_random(20);
    endtask

    task automatic test_calm_tail();
        set_all(15'h7000, 12'd1536, 16'd52000, 24'h300000, 24'h040000, 13'd512, 1'b0);
        calm = 1'b1;
        send_random(110);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.audio_left = '0;
        in_if.audio_right = '0;
        in_if.key_left = '0;
        in_if.key_right = '0;
        in_if.block_last = 1'b0;
        out_if.ready = 1'b1;
        errors = 0;
        frames_sent = 0;
        frames_checked = 0;
        cfg_writes = 0;
        cycles = 0;
        calm = 1'b0;
        stall_left = 0;
        cfg.threshold_db = -15'sd5120;
        cfg.knee_width_db = 12'd768;
        cfg.comp_slope = 16'd49152;
        cfg.attack_coeff = 24'd34917;
        cfg.release_coeff = 24'd3495;
        cfg.makeup_db = 13'd0;
        cfg.use_key = 1'b0;
        env_lvl = 0;
        peak_gr = 0;
        meter_lvl = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_default_random();
        test_soft_knee();
        test_sidechain();
        test_extremes();
        test_calm_tail();

        while (gained_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        $display("Sent %0d frames, checked %0d results, %0d register writes.",
                 frames_sent, frames_checked, cfg_writes);
        $display("Covered soft and hard knee, key detection, makeup, meter blocks, silence.");
        if (errors == 0 && gained_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, gained_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
